### sv/nfa_pkg.sv
// Package for the NFA set stepper: request type and edge codes, sizes.
// Used by the top module and the testbench; depends on nothing.
package nfa_pkg;
  localparam int NFA_STATES_DEF = 64;
  localparam int RANK_BITS_DEF = 16;
  localparam int IDX_W = 6;
  localparam int SUCC_W = 7;

  typedef enum logic [1:0] {
    REQ_WR_STATE = 2'd0,
    REQ_WR_CLASS = 2'd1,
    REQ_START    = 2'd2,
    REQ_STEP     = 2'd3
  } req_t;

  localparam logic [1:0] EDGE_CHAR  = 2'd0;
  localparam logic [1:0] EDGE_EPS   = 2'd1;
  localparam logic [1:0] EDGE_CLASS = 2'd2;
  localparam logic [1:0] EDGE_NONE  = 2'd3;
endpackage

### sv/nfa_if.sv
// Valid/ready channel interfaces for the NFA stepper.
// Depends on nothing.
interface nfa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  state_index;
  logic [1:0]  edge_kind;
  logic [7:0]  edge_char;
  logic [6:0]  next_index;
  logic [6:0]  next2_index;
  logic        accept_valid;
  logic [15:0] accept_rank;
  logic [1:0]  anchor_mode;
  logic [63:0] class_word;
  logic [1:0]  class_word_sel;
  logic [7:0]  symbol;
  modport source (output valid, req_type, state_index, edge_kind, edge_char, next_index,
                  next2_index, accept_valid, accept_rank, anchor_mode, class_word,
                  class_word_sel, symbol, input ready);
  modport sink (input valid, req_type, state_index, edge_kind, edge_char, next_index,
                next2_index, accept_valid, accept_rank, anchor_mode, class_word,
                class_word_sel, symbol, output ready);
endinterface

interface nfa_out_if;
  logic        valid;
  logic        ready;
  logic        set_empty;
  logic        accept_found;
  logic [5:0]  accept_state;
  logic [15:0] accept_rank_out;
  logic [1:0]  accept_anchor;
  modport source (output valid, set_empty, accept_found, accept_state, accept_rank_out,
                  accept_anchor, input ready);
  modport sink (input valid, set_empty, accept_found, accept_state, accept_rank_out,
                accept_anchor, output ready);
endinterface

### sv/nfa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module nfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/nfa_set_step_with_closure_top.sv
// NFA set stepper. A table write gives its result the cycle after the transfer.
// A step scans all states (a read and an evaluate state for each), pushes the members,
// then pops the closure stack through S_POPR, S_POPT and S_POPE, plus S_PUSH2 when a
// state pushes two successors; a start skips the scan.
// One request at a time; ready again the cycle after the result transfer.
// Reset (synchronous, rst_n low) clears the active set and control; tables stay undefined.
module nfa_set_step_with_closure_top #(
  parameter int NFA_STATES = nfa_pkg::NFA_STATES_DEF,
  parameter int RANK_BITS  = nfa_pkg::RANK_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  nfa_in_if.sink    in_ch,
  nfa_out_if.source out_ch
);
  localparam int IW = nfa_pkg::IDX_W;
  // the rank input carries 16 bits, so no more than 16 are ever kept
  localparam int RW = (RANK_BITS < 16) ? RANK_BITS : 16;
  localparam int EW = 2 + 8 + 7 + 7 + 1 + RW + 2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCANR = 9'b000000010,
    S_SCANE = 9'b000000100,
    S_SEED  = 9'b000001000,
    S_POPR  = 9'b000010000,
    S_POPT  = 9'b000100000,
    S_POPE  = 9'b001000000,
    S_PUSH2 = 9'b010000000,
    S_OUT   = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;
  logic [NFA_STATES-1:0] set_r, moved_r;
  logic [IW:0]   i_r;
  logic [IW:0]   sp_r;
  logic [7:0]    sym_r;
  logic          found_r;
  logic [IW-1:0] win_r;
  logic [RW-1:0] wrank_r;
  logic [1:0]    wanc_r;
  logic [IW-1:0] cur_r;
  logic [IW-1:0] nx2_r;
  logic          o_empty_r, o_found_r;
  logic [IW-1:0] o_state_r;
  logic [15:0]   o_rank_r;
  logic [1:0]    o_anc_r;

  // state entry fields
  logic [EW-1:0] ent_w, ent_rd;
  logic          ent_we;
  logic [IW-1:0] ent_ra;
  logic [63:0]   cls_rd;
  logic          cls_we;
  logic [7:0]    cls_ra;

  // closure stack port
  logic          stk_we;
  logic [IW-1:0] stk_wa, stk_wd, stk_ra, stk_rd;

  assign ent_w = {in_ch.edge_kind, in_ch.edge_char, in_ch.next_index, in_ch.next2_index,
                  in_ch.accept_valid, in_ch.accept_rank[RW-1:0], in_ch.anchor_mode};

  logic [1:0] e_kind;
  logic [7:0] e_ch;
  logic [6:0] e_nx, e_nx2;
  logic       e_acc;
  logic [RW-1:0] e_rank;
  logic [1:0] e_anc;
  assign {e_kind, e_ch, e_nx, e_nx2, e_acc, e_rank, e_anc} = ent_rd;

  logic accept_in;
  assign in_ch.ready = (st_r == S_IDLE);
  assign accept_in = in_ch.valid && in_ch.ready;
  logic idx_ok;
  assign idx_ok = 32'(in_ch.state_index) < NFA_STATES;

  assign ent_we = accept_in && in_ch.req_type == nfa_pkg::REQ_WR_STATE && idx_ok;
  assign cls_we = accept_in && in_ch.req_type == nfa_pkg::REQ_WR_CLASS && idx_ok;

  // during a pop the table address comes straight from the stack read data
  assign ent_ra = (st_r == S_POPT) ? stk_rd : i_r[IW-1:0];
  assign cls_ra = {i_r[IW-1:0], sym_r[7:6]};
  assign stk_ra = sp_r[IW-1:0] - 1'b1;

  nfa_ram #(.WIDTH(EW), .DEPTH(64)) u_ent (
    .clk(clk), .we(ent_we), .waddr(in_ch.state_index), .wdata(ent_w),
    .raddr(ent_ra), .rdata(ent_rd));
  nfa_ram #(.WIDTH(64), .DEPTH(256)) u_cls (
    .clk(clk), .we(cls_we), .waddr({in_ch.state_index, in_ch.class_word_sel}),
    .wdata(in_ch.class_word), .raddr(cls_ra), .rdata(cls_rd));
  nfa_ram #(.WIDTH(IW), .DEPTH(64)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .raddr(stk_ra), .rdata(stk_rd));

  logic hit;
  always_comb begin
    hit = 1'b0;
    if (e_kind == nfa_pkg::EDGE_CHAR) hit = (e_ch == sym_r);
    else if (e_kind == nfa_pkg::EDGE_CLASS) hit = cls_rd[sym_r[5:0]];
  end

  logic nx_ok, nx2_ok;
  assign nx_ok = 32'(e_nx) < NFA_STATES;
  assign nx2_ok = 32'(e_nx2) < NFA_STATES;

  // epsilon successors not yet in the set; a repeated successor is pushed once
  logic push1, push2, better;
  always_comb begin
    push1 = 1'b0;
    push2 = 1'b0;
    if (e_kind == nfa_pkg::EDGE_EPS) begin
      push1 = nx_ok && !set_r[e_nx[IW-1:0]];
      push2 = nx2_ok && !set_r[e_nx2[IW-1:0]] && !(push1 && e_nx2 == e_nx);
    end
  end
  // first accepting state popped always wins; later ones need a strictly lower rank
  assign better = e_acc && (!found_r || e_rank < wrank_r);

  always_comb begin
    stk_we = 1'b0;
    stk_wa = sp_r[IW-1:0];
    stk_wd = i_r[IW-1:0];
    if (st_r == S_SEED) begin
      stk_we = (32'(i_r) < NFA_STATES) && set_r[i_r[IW-1:0]];
    end else if (st_r == S_POPE) begin
      stk_we = push1 || push2;
      stk_wd = push1 ? e_nx[IW-1:0] : e_nx2[IW-1:0];
    end else if (st_r == S_PUSH2) begin
      stk_we = 1'b1;
      stk_wa = sp_r[IW-1:0] - 1'b1;
      stk_wd = nx2_r;
    end
  end

  always_comb begin
    unique case (st_r)
      S_IDLE:  st_nxt = !accept_in ? S_IDLE :
                        (in_ch.req_type == nfa_pkg::REQ_STEP) ? S_SCANR :
                        (in_ch.req_type == nfa_pkg::REQ_START) ? S_SEED : S_OUT;
      S_SCANR: st_nxt = S_SCANE;
      S_SCANE: st_nxt = (32'(i_r) == NFA_STATES - 1) ? S_SEED : S_SCANR;
      S_SEED:  st_nxt = (32'(i_r) >= NFA_STATES) ? ((sp_r == '0) ? S_OUT : S_POPR) : S_SEED;
      S_POPR:  st_nxt = S_POPT;
      S_POPT:  st_nxt = S_POPE;
      S_POPE:  st_nxt = (push1 && push2) ? S_PUSH2 :
                        (sp_r == '0 && !push1 && !push2) ? S_OUT : S_POPR;
      S_PUSH2: st_nxt = S_POPR;
      S_OUT:   st_nxt = out_ch.ready ? S_IDLE : S_OUT;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      set_r <= '0;
      sp_r <= '0;
      i_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: if (accept_in) begin
          i_r <= '0;
          sp_r <= '0;
          found_r <= 1'b0;
          win_r <= '0; wrank_r <= '0; wanc_r <= '0;
          sym_r <= in_ch.symbol;
          moved_r <= '0;
          if (in_ch.req_type == nfa_pkg::REQ_START)
            set_r <= idx_ok ? (NFA_STATES'(1) << in_ch.state_index) : '0;
        end
        S_SCANR: ;
        S_SCANE: begin
          if (set_r[i_r[IW-1:0]] && hit && nx_ok)
            moved_r <= moved_r | (NFA_STATES'(1) << e_nx[IW-1:0]);
          if (32'(i_r) == NFA_STATES - 1) begin
            set_r <= moved_r |
                     ((set_r[i_r[IW-1:0]] && hit && nx_ok) ?
                      (NFA_STATES'(1) << e_nx[IW-1:0]) : '0);
            i_r <= '0;
          end else i_r <= i_r + 1'b1;
        end
        S_SEED: if (32'(i_r) < NFA_STATES) begin
          // push members in ascending order, one per cycle
          if (set_r[i_r[IW-1:0]]) sp_r <= sp_r + 1'b1;
          i_r <= i_r + 1'b1;
        end
        S_POPR: sp_r <= sp_r - 1'b1;
        S_POPT: cur_r <= stk_rd;
        S_POPE: begin
          if (better) begin
            found_r <= 1'b1; win_r <= cur_r; wrank_r <= e_rank; wanc_r <= e_anc;
          end
          set_r <= set_r | (push1 ? (NFA_STATES'(1) << e_nx[IW-1:0]) : '0) |
                   (push2 ? (NFA_STATES'(1) << e_nx2[IW-1:0]) : '0);
          sp_r <= sp_r + {{IW{1'b0}}, push1} + {{IW{1'b0}}, push2};
          nx2_r <= e_nx2[IW-1:0];
        end
        S_PUSH2: ;
        S_OUT: ;
        default: ;
      endcase
    end
  end

  // result register, loaded on the way into S_OUT
  always_ff @(posedge clk) begin
    if (st_nxt == S_OUT && st_r != S_OUT) begin
      o_empty_r <= (set_r == '0);
      o_found_r <= 1'b0; o_state_r <= '0; o_rank_r <= '0; o_anc_r <= '0;
      if (st_r == S_POPE) begin
        if (better) begin
          o_found_r <= 1'b1; o_state_r <= cur_r; o_rank_r <= 16'(e_rank); o_anc_r <= e_anc;
        end else if (found_r) begin
          o_found_r <= 1'b1; o_state_r <= win_r; o_rank_r <= 16'(wrank_r); o_anc_r <= wanc_r;
        end
      end
    end
  end

  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.set_empty = o_empty_r;
  assign out_ch.accept_found = o_found_r;
  assign out_ch.accept_state = o_state_r;
  assign out_ch.accept_rank_out = o_rank_r;
  assign out_ch.accept_anchor = o_anc_r;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= NFA_STATES) else $error("stack overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_POPR) |-> (sp_r != '0)) else $error("pop from empty stack");
`endif
endmodule

### sim/tb_top.sv
// Testbench for nfa_set_step_with_closure_top: loads an NFA table, then runs directed and
// random start/step/write traffic and checks every result against an in-bench NFA model.
// Depends on nfa_pkg (sv/nfa_pkg.sv) and the channel interfaces (sv/nfa_if.sv).
module tb_top;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int RANDOM_ITEMS   = 870;
  localparam int RANK_START     = 32'h7fffffff;
  localparam logic [6:0] NO_SUCC = 7'd64;

  typedef struct packed {
    nfa_pkg::req_t req_type;
    logic [5:0]  state_index;
    logic [1:0]  edge_kind;
    logic [7:0]  edge_char;
    logic [6:0]  next_index;
    logic [6:0]  next2_index;
    logic        accept_valid;
    logic [15:0] accept_rank;
    logic [1:0]  anchor_mode;
    logic [63:0] class_word;
    logic [1:0]  class_word_sel;
    logic [7:0]  symbol;
  } nfa_req_item_t;

  typedef struct packed {
    logic        set_empty;
    logic        accept_found;
    logic [5:0]  accept_state;
    logic [15:0] accept_rank_out;
    logic [1:0]  accept_anchor;
  } nfa_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nfa_in_if  in_ch();
  nfa_out_if out_ch();

  nfa_set_step_with_closure_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // NFA model state
  logic [1:0]  nfa_kind  [0:63];
  logic [7:0]  nfa_char  [0:63];
  logic [6:0]  nfa_next  [0:63];
  logic [6:0]  nfa_next2 [0:63];
  logic        nfa_acc   [0:63];
  logic [15:0] nfa_rank  [0:63];
  logic [1:0]  nfa_anchor[0:63];
  logic [63:0] class_mem [0:255];
  logic [63:0] live_set;

  nfa_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  function automatic nfa_result_t close_and_report();
    logic [5:0] stk [0:63];
    int sp;
    int best;
    nfa_result_t r;
    logic [5:0] cur;
    logic [6:0] succ;
    sp = 0;
    best = RANK_START;
    r = '0;
    for (int i = 0; i < 64; i++)
      if (live_set[i]) begin
        stk[sp] = i[5:0];
        sp++;
      end
    while (sp > 0) begin
      sp--;
      cur = stk[sp];
      if (nfa_acc[cur] && int'(nfa_rank[cur]) < best) begin
        best = int'(nfa_rank[cur]);
        r.accept_found = 1'b1;
        r.accept_state = cur;
        r.accept_rank_out = nfa_rank[cur];
        r.accept_anchor = nfa_anchor[cur];
      end
      if (nfa_kind[cur] == nfa_pkg::EDGE_EPS)
        for (int k = 0; k < 2; k++) begin
          succ = (k == 0) ? nfa_next[cur] : nfa_next2[cur];
          if (succ < 7'd64 && !live_set[succ[5:0]] && sp < 64) begin
            live_set[succ[5:0]] = 1'b1;
            stk[sp] = succ[5:0];
            sp++;
          end
        end
    end
    r.set_empty = (live_set == '0);
    return r;
  endfunction

  function automatic nfa_result_t apply_request(nfa_req_item_t it);
    nfa_result_t r;
    logic [63:0] moved;
    logic hit;
    logic [7:0] c;
    r = '0;
    case (it.req_type)
      nfa_pkg::REQ_WR_STATE: begin
        nfa_kind[it.state_index]   = it.edge_kind;
        nfa_char[it.state_index]   = it.edge_char;
        nfa_next[it.state_index]   = it.next_index;
        nfa_next2[it.state_index]  = it.next2_index;
        nfa_acc[it.state_index]    = it.accept_valid;
        nfa_rank[it.state_index]   = it.accept_rank;
        nfa_anchor[it.state_index] = it.anchor_mode;
        r.set_empty = (live_set == '0);
      end
      nfa_pkg::REQ_WR_CLASS: begin
        class_mem[{it.state_index, it.class_word_sel}] = it.class_word;
        r.set_empty = (live_set == '0);
      end
      nfa_pkg::REQ_START: begin
        live_set = '0;
        live_set[it.state_index] = 1'b1;
        r = close_and_report();
      end
      default: begin
        c = it.symbol;
        moved = '0;
        for (int i = 0; i < 64; i++) begin
          if (!live_set[i]) continue;
          hit = 1'b0;
          if (nfa_kind[i] == nfa_pkg::EDGE_CHAR && nfa_char[i] == c) hit = 1'b1;
          else if (nfa_kind[i] == nfa_pkg::EDGE_CLASS)
            hit = class_mem[{i[5:0], c[7:6]}][c[5:0]];
          if (hit && nfa_next[i] < 7'd64) moved[nfa_next[i][5:0]] = 1'b1;
        end
        live_set = moved;
        r = close_and_report();
      end
    endcase
    return r;
  endfunction

  // Drive at the falling edge; valid stays high across back-to-back transfers.
  task automatic send_request(nfa_req_item_t it);
    if (!no_idle && $urandom_range(99) < 17) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_ch.req_type       = it.req_type;
    in_ch.state_index    = it.state_index;
    in_ch.edge_kind      = it.edge_kind;
    in_ch.edge_char      = it.edge_char;
    in_ch.next_index     = it.next_index;
    in_ch.next2_index    = it.next2_index;
    in_ch.accept_valid   = it.accept_valid;
    in_ch.accept_rank    = it.accept_rank;
    in_ch.anchor_mode    = it.anchor_mode;
    in_ch.class_word     = it.class_word;
    in_ch.class_word_sel = it.class_word_sel;
    in_ch.symbol         = it.symbol;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_request(it));
    @(negedge clk);
  endtask

  function automatic nfa_req_item_t noise_item(nfa_pkg::req_t rq);
    nfa_req_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = nfa_req_item_t'(raw[$bits(nfa_req_item_t)-1:0]);
    it.req_type = rq;
    return it;
  endfunction

  function automatic logic [6:0] pick_succ();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 7'($urandom_range(63));
    if (r < 95) return NO_SUCC;
    return 7'($urandom_range(127, 64));
  endfunction

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(99) < 80) return 8'($urandom_range(8'h63, 8'h61));
    return 8'($urandom);
  endfunction

  function automatic nfa_req_item_t state_item(logic [5:0] idx);
    nfa_req_item_t it;
    int r;
    it = noise_item(nfa_pkg::REQ_WR_STATE);
    it.state_index = idx;
    r = $urandom_range(99);
    it.edge_kind = (r < 35) ? nfa_pkg::EDGE_CHAR : (r < 70) ? nfa_pkg::EDGE_EPS :
                   (r < 90) ? nfa_pkg::EDGE_CLASS : nfa_pkg::EDGE_NONE;
    it.edge_char = pick_symbol();
    it.next_index = pick_succ();
    it.next2_index = pick_succ();
    it.accept_valid = ($urandom_range(99) < 30);
    // small ranks make ties between accepting states likely
    it.accept_rank = ($urandom_range(99) < 70) ? 16'($urandom_range(7)) : 16'($urandom);
    return it;
  endfunction

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_table_load();
    nfa_req_item_t it;
    for (int i = 0; i < 64; i++) send_request(state_item(i[5:0]));
    for (int i = 0; i < 256; i++) begin
      it = noise_item(nfa_pkg::REQ_WR_CLASS);
      it.state_index = i[7:2];
      it.class_word_sel = i[1:0];
      send_request(it);
    end
  endtask

  task automatic test_directed();
    nfa_req_item_t it;
    // empty set before any start
    it = noise_item(nfa_pkg::REQ_STEP); send_request(it);
    // 0: eps -> 1, 2 ; both accepting with equal rank; 63 has max rank, also checked later
    it = noise_item(nfa_pkg::REQ_WR_STATE);
    it.state_index = 6'd0; it.edge_kind = nfa_pkg::EDGE_EPS; it.next_index = 7'd1;
    it.next2_index = 7'd2; it.accept_valid = 1'b0; send_request(it);
    it = noise_item(nfa_pkg::REQ_WR_STATE);
    it.state_index = 6'd1; it.edge_kind = nfa_pkg::EDGE_CHAR; it.edge_char = 8'hff;
    it.next_index = 7'd63;
    it.accept_valid = 1'b1; it.accept_rank = 16'd5; it.anchor_mode = 2'd3; send_request(it);
    it = noise_item(nfa_pkg::REQ_WR_STATE);
    it.state_index = 6'd2; it.edge_kind = nfa_pkg::EDGE_CLASS; it.next_index = 7'd63;
    it.accept_valid = 1'b1; it.accept_rank = 16'd5; it.anchor_mode = 2'd1; send_request(it);
    it = noise_item(nfa_pkg::REQ_WR_CLASS);
    it.state_index = 6'd2; it.class_word_sel = 2'd0; it.class_word = 64'h1; send_request(it);
    it = noise_item(nfa_pkg::REQ_WR_STATE);
    it.state_index = 6'd63; it.edge_kind = nfa_pkg::EDGE_NONE; it.next_index = 7'd127;
    it.next2_index = NO_SUCC;
    it.accept_valid = 1'b1; it.accept_rank = 16'hffff; it.anchor_mode = 2'd2; send_request(it);
    it = noise_item(nfa_pkg::REQ_START); it.state_index = 6'd0; send_request(it);
    it = noise_item(nfa_pkg::REQ_STEP); it.symbol = 8'hff; send_request(it);
    it = noise_item(nfa_pkg::REQ_START); it.state_index = 6'd0; send_request(it);
    it = noise_item(nfa_pkg::REQ_STEP); it.symbol = 8'h00; send_request(it);
    // state with no edge: step leaves nothing
    it = noise_item(nfa_pkg::REQ_STEP); it.symbol = 8'h00; send_request(it);
    it = noise_item(nfa_pkg::REQ_START); it.state_index = 6'd63; send_request(it);
    // matching edge without successor
    it = noise_item(nfa_pkg::REQ_WR_STATE);
    it.state_index = 6'd1; it.edge_kind = nfa_pkg::EDGE_CHAR; it.edge_char = 8'h00;
    it.next_index = NO_SUCC; it.accept_valid = 1'b1; it.accept_rank = 16'd0; send_request(it);
    it = noise_item(nfa_pkg::REQ_START); it.state_index = 6'd1; send_request(it);
    it = noise_item(nfa_pkg::REQ_STEP); it.symbol = 8'h00; send_request(it);
    drain_results();
  endtask

  task automatic test_random();
    nfa_req_item_t it;
    int r;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 400 && n < 550);
      if (n == 800) drain_results();
      r = $urandom_range(99);
      if (r < 6) send_request(state_item(6'($urandom)));
      else if (r < 10) send_request(noise_item(nfa_pkg::REQ_WR_CLASS));
      else if (r < 25) send_request(noise_item(nfa_pkg::REQ_START));
      else begin
        it = noise_item(nfa_pkg::REQ_STEP);
        it.symbol = pick_symbol();
        send_request(it);
      end
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk)
    out_ch.ready <= no_idle || ($urandom_range(99) >= 17);

  always @(posedge clk) begin
    nfa_result_t got;
    nfa_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.set_empty, out_ch.accept_found, out_ch.accept_state,
             out_ch.accept_rank_out, out_ch.accept_anchor};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.set_empty !== want.set_empty) begin
          $display("%0t: set_empty exp %h got %h", $time, want.set_empty, got.set_empty);
          errors++;
        end
        if (got.accept_found !== want.accept_found) begin
          $display("%0t: accept_found exp %h got %h", $time, want.accept_found,
                   got.accept_found);
          errors++;
        end
        if (got.accept_state !== want.accept_state) begin
          $display("%0t: accept_state exp %0d got %0d", $time, want.accept_state,
                   got.accept_state);
          errors++;
        end
        if (got.accept_rank_out !== want.accept_rank_out) begin
          $display("%0t: accept_rank_out exp %0d got %0d", $time, want.accept_rank_out,
                   got.accept_rank_out);
          errors++;
        end
        if (got.accept_anchor !== want.accept_anchor) begin
          $display("%0t: accept_anchor exp %0d got %0d", $time, want.accept_anchor,
                   got.accept_anchor);
          errors++;
        end
      end
    end
  end

  // Count cycles without any transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.req_type, in_ch.state_index, in_ch.edge_kind, in_ch.edge_char, in_ch.next_index,
     in_ch.next2_index, in_ch.accept_valid, in_ch.accept_rank, in_ch.anchor_mode,
     in_ch.class_word, in_ch.class_word_sel, in_ch.symbol} = '0;
    out_ch.ready = 1'b0;
    live_set = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_table_load();
    test_directed();
    test_random();
    in_ch.valid = 1'b0;
    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
